### rtl/core/jtl_pkg.sv
// Shared types and constants of the Jacobian torque limiter.
// No dependencies; every other file of the block but jtl_ram refers to it by scoped names.

package jtl_pkg;

   localparam int MAX_JOINTS = 8;
   localparam int AXES       = 6;
   localparam int JOINT_AW   = (MAX_JOINTS > 1) ? $clog2(MAX_JOINTS) : 1;

   localparam int DATA_W    = 32;
   localparam int CFG_W     = 31;
   localparam int DT_W      = 24;
   localparam int SLOT_W    = 3;
   localparam int KIND_W    = 2;
   localparam int FRAC_W    = 16;
   localparam int CSR_IDX_W = 2;

   localparam int PROD_W  = 2 * DATA_W;
   localparam int PAIRS   = (AXES + 1) / 2;
   localparam int PAIR_W  = PROD_W + 1;
   localparam int TOTAL_W = PROD_W + $clog2(AXES) + 1;
   localparam int TAU_W   = TOTAL_W - FRAC_W + 1;
   localparam int RATE_W  = CFG_W + DT_W;

   typedef enum logic [KIND_W-1:0] {
      KIND_WRENCH = 2'd0,
      KIND_JOINT  = 2'd1,
      KIND_CLEAR  = 2'd2
   } kind_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TORQUE_LIMIT = 2'd0,
      CSR_RATE_LIMIT   = 2'd1,
      CSR_STIFFNESS    = 2'd2,
      CSR_DAMPING      = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [KIND_W-1:0]        kind;
      logic [SLOT_W-1:0]        slot;
      logic signed [DATA_W-1:0] value;
      logic signed [DATA_W-1:0] jac_0;
      logic signed [DATA_W-1:0] jac_1;
      logic signed [DATA_W-1:0] jac_2;
      logic signed [DATA_W-1:0] jac_3;
      logic signed [DATA_W-1:0] jac_4;
      logic signed [DATA_W-1:0] jac_5;
      logic [DT_W-1:0]          step_time;
      logic                     handle_ok;
      logic                     final_joint;
   } req_type;

   typedef struct packed {
      logic [SLOT_W-1:0]        joint_id;
      logic signed [DATA_W-1:0] torque_out;
      logic [CFG_W-1:0]         stiffness_out;
      logic [CFG_W-1:0]         damping_out;
      logic                     command_ok;
      logic                     frame_end;
   } rsp_type;

endpackage

### rtl/core/jtl_req_if.sv
// Input channel of the Jacobian torque limiter: valid, ready and one request.
// Depends on jtl_pkg for the payload type.

interface jtl_req_if;
   logic             valid;
   logic             ready;
   jtl_pkg::req_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

### rtl/core/jtl_rsp_if.sv
// Result channel of the Jacobian torque limiter: valid, ready and one command.
// Depends on jtl_pkg for the payload type.

interface jtl_rsp_if;
   logic             valid;
   logic             ready;
   jtl_pkg::rsp_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

### rtl/core/jtl_ram.sv
// Generic single-write, single-read RAM with registered, read-first output.
// No dependencies.

module jtl_ram #(
   parameter int WIDTH  = 32,
   parameter int DEPTH  = 8,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

endmodule

### rtl/core/jtl_dot.sv
// Pipelined six-axis dot product of Jacobian row and wrench, exact in Q36.32.
// Depends on jtl_pkg; products, pair sums and total take one stage each.

module jtl_dot (
   input  logic                                clock,
   input  logic                                advance,
   input  logic signed [jtl_pkg::DATA_W-1:0]   jac    [jtl_pkg::AXES],
   input  logic signed [jtl_pkg::DATA_W-1:0]   wrench [jtl_pkg::AXES],
   output logic signed [jtl_pkg::TOTAL_W-1:0]  total
);

   logic signed [jtl_pkg::PROD_W-1:0]  prod_ff  [jtl_pkg::AXES];
   logic signed [jtl_pkg::PAIR_W-1:0]  pair_ff  [jtl_pkg::PAIRS];
   logic signed [jtl_pkg::PAIR_W-1:0]  pair_in  [jtl_pkg::PAIRS];
   logic signed [jtl_pkg::TOTAL_W-1:0] total_in;
   logic signed [jtl_pkg::TOTAL_W-1:0] total_ff;

   always_comb begin
      for (int p = 0; p < jtl_pkg::PAIRS; p++) begin
         if (2 * p + 1 < jtl_pkg::AXES) begin
            pair_in[p] = jtl_pkg::PAIR_W'(prod_ff[2*p]) + jtl_pkg::PAIR_W'(prod_ff[2*p+1]);
         end else begin
            pair_in[p] = jtl_pkg::PAIR_W'(prod_ff[2*p]);
         end
      end
   end

   always_comb begin
      total_in = '0;
      for (int p = 0; p < jtl_pkg::PAIRS; p++) begin
         total_in = total_in + jtl_pkg::TOTAL_W'(pair_ff[p]);
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int a = 0; a < jtl_pkg::AXES; a++) begin
            prod_ff[a] <= jac[a] * wrench[a];
         end
         pair_ff  <= pair_in;
         total_ff <= total_in;
      end
   end

   assign total = total_ff;

endmodule

### rtl/core/jacobian_torque_limiter.sv
// Jacobian torque limiter: a joint request (kind 1) returns its limited torque
// command, and one request is taken every cycle
// while the result side keeps up. The six Jacobian products, their pair sums
// and the total each take one stage, the absolute clamp a fourth, and the last
// stage applies the slew clamp against the joint's previous torque. That
// history sits in an eight-entry RAM read one stage ahead and written back as
// the command leaves; a same-joint command one stage ahead is forwarded.
// Wrench loads (kind 0) and history clears (kind 2) act at acceptance and
// return nothing. Depends on jtl_pkg, jtl_req_if, jtl_rsp_if, jtl_ram, jtl_dot.

module jacobian_torque_limiter (
   input  logic                              clock,
   input  logic                              reset,
   jtl_req_if.sink                           req_chan,
   jtl_rsp_if.source                         rsp_chan,
   input  logic                              csr_we,
   input  logic [jtl_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [jtl_pkg::CFG_W-1:0]         csr_wdata
);

   typedef struct packed {
      logic                              valid;
      logic [jtl_pkg::SLOT_W-1:0]        slot;
      logic signed [jtl_pkg::DATA_W-1:0] value;
      logic [jtl_pkg::DT_W-1:0]          step_time;
      logic                              ok;
      logic                              fin;
      logic                              hist;
   } meta_type;

   logic [jtl_pkg::CFG_W-1:0] torque_limit_ff;
   logic [jtl_pkg::CFG_W-1:0] rate_limit_ff;
   logic [jtl_pkg::CFG_W-1:0] stiffness_ff;
   logic [jtl_pkg::CFG_W-1:0] damping_ff;

   logic signed [jtl_pkg::DATA_W-1:0] wrench_ff [jtl_pkg::AXES];
   logic signed [jtl_pkg::DATA_W-1:0] jac_row   [jtl_pkg::AXES];
   logic                              history_ff;

   logic       advance;
   logic       accept;
   logic       joint_ok;
   jtl_pkg::req_type req;

   meta_type m1_ff, m2_ff, m3_ff, m4_ff;
   meta_type m1_in;

   logic [jtl_pkg::RATE_W-1:0] rate_prod;
   logic [jtl_pkg::CFG_W-1:0]  delta_m2_ff, delta_m3_ff, delta_m4_ff;

   logic signed [jtl_pkg::TOTAL_W-1:0] total;
   logic signed [jtl_pkg::TAU_W-1:0]   tau_raw;
   logic signed [jtl_pkg::TAU_W-1:0]   lim_ext;
   logic signed [jtl_pkg::DATA_W-1:0]  tau_lim_in;
   logic signed [jtl_pkg::DATA_W-1:0]  tau_lim_ff;

   logic [jtl_pkg::DATA_W-1:0]         ram_rdata;
   logic                               fwd_ff;
   logic signed [jtl_pkg::DATA_W-1:0]  fwd_data_ff;
   logic signed [jtl_pkg::DATA_W-1:0]  prev;
   logic signed [jtl_pkg::DATA_W:0]    slew_lo;
   logic signed [jtl_pkg::DATA_W:0]    slew_hi;
   logic signed [jtl_pkg::DATA_W:0]    tau_ext;
   logic signed [jtl_pkg::DATA_W-1:0]  tau_final_in;
   logic                               hist_wr;

   logic             rsp_valid_ff;
   jtl_pkg::rsp_type rsp_data_ff;
   jtl_pkg::rsp_type rsp_data_in;

   assign req     = req_chan.data;
   assign advance = !rsp_valid_ff || rsp_chan.ready;
   assign accept  = req_chan.valid && advance;
   assign req_chan.ready = advance;

   assign joint_ok = req.handle_ok && (int'(req.slot) < jtl_pkg::MAX_JOINTS);

   always_ff @(posedge clock) begin
      if (reset) begin
         torque_limit_ff <= '0;
         rate_limit_ff   <= '0;
         stiffness_ff    <= '0;
         damping_ff      <= '0;
      end else if (csr_we) begin
         unique case (jtl_pkg::csr_index_type'(csr_index))
            jtl_pkg::CSR_TORQUE_LIMIT: torque_limit_ff <= csr_wdata;
            jtl_pkg::CSR_RATE_LIMIT:   rate_limit_ff   <= csr_wdata;
            jtl_pkg::CSR_STIFFNESS:    stiffness_ff    <= csr_wdata;
            jtl_pkg::CSR_DAMPING:      damping_ff      <= csr_wdata;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (accept && req.kind == jtl_pkg::KIND_WRENCH &&
          int'(req.slot) < jtl_pkg::AXES) begin
         wrench_ff[req.slot] <= req.value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         history_ff <= 1'b0;
      end else if (accept) begin
         priority if (req.kind == jtl_pkg::KIND_CLEAR) begin
            history_ff <= 1'b0;
         end else if (req.kind == jtl_pkg::KIND_JOINT && joint_ok && req.final_joint) begin
            history_ff <= 1'b1;
         end
      end
   end

   assign jac_row[0] = req.jac_0;
   assign jac_row[1] = req.jac_1;
   assign jac_row[2] = req.jac_2;
   assign jac_row[3] = req.jac_3;
   assign jac_row[4] = req.jac_4;
   assign jac_row[5] = req.jac_5;

   jtl_dot u_dot (
      .clock   (clock),
      .advance (advance),
      .jac     (jac_row),
      .wrench  (wrench_ff),
      .total   (total)
   );

   always_comb begin
      m1_in.valid     = accept && req.kind == jtl_pkg::KIND_JOINT;
      m1_in.slot      = req.slot;
      m1_in.value     = req.value;
      m1_in.step_time = req.step_time;
      m1_in.ok        = joint_ok;
      m1_in.fin       = req.final_joint;
      m1_in.hist      = history_ff;
   end

   assign rate_prod = jtl_pkg::RATE_W'(rate_limit_ff) * jtl_pkg::RATE_W'(m1_ff.step_time);

   always_comb begin
      tau_raw = jtl_pkg::TAU_W'($signed(total[jtl_pkg::TOTAL_W-1:jtl_pkg::FRAC_W]))
              + jtl_pkg::TAU_W'(m3_ff.value);
      lim_ext = jtl_pkg::TAU_W'({1'b0, torque_limit_ff});
      priority if (tau_raw > lim_ext) begin
         tau_lim_in = jtl_pkg::DATA_W'(lim_ext);
      end else if (tau_raw < -lim_ext) begin
         tau_lim_in = jtl_pkg::DATA_W'(-lim_ext);
      end else begin
         tau_lim_in = jtl_pkg::DATA_W'(tau_raw);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m1_ff.valid <= 1'b0;
         m2_ff.valid <= 1'b0;
         m3_ff.valid <= 1'b0;
         m4_ff.valid <= 1'b0;
         fwd_ff      <= 1'b0;
      end else if (advance) begin
         m1_ff  <= m1_in;
         m2_ff  <= m1_ff;
         m3_ff  <= m2_ff;
         m4_ff  <= m3_ff;
         fwd_ff <= hist_wr && m3_ff.valid && m3_ff.slot == m4_ff.slot;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         delta_m2_ff <= rate_prod[jtl_pkg::RATE_W-1:jtl_pkg::DT_W];
         delta_m3_ff <= delta_m2_ff;
         delta_m4_ff <= delta_m3_ff;
         tau_lim_ff  <= tau_lim_in;
         fwd_data_ff <= tau_final_in;
      end
   end

   jtl_ram #(
      .WIDTH (jtl_pkg::DATA_W),
      .DEPTH (jtl_pkg::MAX_JOINTS)
   ) u_last_torque (
      .clock   (clock),
      .wr_en   (hist_wr),
      .wr_addr (m4_ff.slot[jtl_pkg::JOINT_AW-1:0]),
      .wr_data (tau_final_in),
      .rd_en   (advance),
      .rd_addr (m3_ff.slot[jtl_pkg::JOINT_AW-1:0]),
      .rd_data (ram_rdata)
   );

   assign hist_wr = advance && m4_ff.valid && m4_ff.ok;

   always_comb begin
      prev    = fwd_ff ? fwd_data_ff : $signed(ram_rdata);
      slew_lo = (jtl_pkg::DATA_W+1)'(prev) - (jtl_pkg::DATA_W+1)'({1'b0, delta_m4_ff});
      slew_hi = (jtl_pkg::DATA_W+1)'(prev) + (jtl_pkg::DATA_W+1)'({1'b0, delta_m4_ff});
      tau_ext = (jtl_pkg::DATA_W+1)'(tau_lim_ff);
      if (m4_ff.hist && m4_ff.step_time != '0) begin
         priority if (tau_ext < slew_lo) begin
            tau_ext = slew_lo;
         end else if (tau_ext > slew_hi) begin
            tau_ext = slew_hi;
         end
      end
      tau_final_in = jtl_pkg::DATA_W'(tau_ext);
   end

   always_comb begin
      rsp_data_in.joint_id   = m4_ff.slot;
      rsp_data_in.frame_end  = m4_ff.fin;
      rsp_data_in.command_ok = m4_ff.ok;
      if (m4_ff.ok) begin
         rsp_data_in.torque_out    = tau_final_in;
         rsp_data_in.stiffness_out = stiffness_ff;
         rsp_data_in.damping_out   = damping_ff;
      end else begin
         rsp_data_in.torque_out    = '0;
         rsp_data_in.stiffness_out = '0;
         rsp_data_in.damping_out   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= m4_ff.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.data  = rsp_data_ff;

endmodule

### rtl/core/jtl_checker.sv
// Port-level assertions for the Jacobian torque limiter, bound to the top level.
// Depends on jtl_pkg and jtl_rsp_if; shadows the stiffness and damping writes.

module jtl_checker (
   input logic                          clock,
   input logic                          reset,
   jtl_rsp_if.source                    rsp_chan,
   input logic                          csr_we,
   input logic [jtl_pkg::CSR_IDX_W-1:0] csr_index,
   input logic [jtl_pkg::CFG_W-1:0]     csr_wdata
);

   logic [jtl_pkg::CFG_W-1:0]       stiff_ff;
   logic [jtl_pkg::CFG_W-1:0]       damp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         stiff_ff <= '0;
         damp_ff  <= '0;
      end else if (csr_we) begin
         if (csr_index == jtl_pkg::CSR_STIFFNESS) begin
            stiff_ff <= csr_wdata;
         end
         if (csr_index == jtl_pkg::CSR_DAMPING) begin
            damp_ff <= csr_wdata;
         end
      end
   end

   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.data.command_ok |->
         rsp_chan.data.torque_out == '0 && rsp_chan.data.stiffness_out == '0 &&
         rsp_chan.data.damping_out == '0)
      else $error("rejected command carries nonzero payload");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_chan.valid)
      else $error("command valid right after reset");

   a_gain_copy: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.data.command_ok |->
         rsp_chan.data.stiffness_out == stiff_ff && rsp_chan.data.damping_out == damp_ff)
      else $error("kp or kd differs from configuration");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.ready |=> rsp_chan.valid && $stable(rsp_chan.data))
      else $error("stalled transaction changed");

endmodule

bind jacobian_torque_limiter jtl_checker u_jtl_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_chan  (rsp_chan),
   .csr_we    (csr_we),
   .csr_index (csr_index),
   .csr_wdata (csr_wdata)
);

### sim/tb_top.sv
`timescale 1ns / 100ps
// Self-checking bench for jacobian_torque_limiter: wrench loads, joint steps and history clears
// driven through jtl_req_if, joint commands checked off jtl_rsp_if against an in-bench predictor.
// Depends on jtl_pkg, jtl_req_if, jtl_rsp_if and the RTL of the block.

module tb_top;
   import jtl_pkg::*;

   localparam int PHASES       = 8;
   localparam int PHASE_ITEMS  = 172;
   localparam int DRAIN_CYCLES = 12;
   localparam int STALL_LIMIT  = 2000;
   localparam int WIDE_W       = 2 * DATA_W + 4;
   localparam logic [CFG_W-1:0]  CFG_MAX     = '1;
   localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

   logic                 clock     = 1'b0;
   logic                 reset     = 1'b1;
   logic                 csr_we    = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_TORQUE_LIMIT;
   logic [CFG_W-1:0]     csr_wdata = '0;

   jtl_req_if req_if ();
   jtl_rsp_if rsp_if ();

   req_type pending_reqs[$];
   rsp_type expected_cmds[$];
   rsp_type want;

   logic [CFG_W-1:0]         limit_reg = '0;
   logic [CFG_W-1:0]         rate_reg  = '0;
   logic [CFG_W-1:0]         kp_reg    = '0;
   logic [CFG_W-1:0]         kd_reg    = '0;
   logic signed [DATA_W-1:0] wrench_axis [AXES];
   logic signed [DATA_W-1:0] prev_torque [MAX_JOINTS];
   bit                       history_valid = 1'b0;

   bit quiet_idle = 1'b0;
   int send_gap, recv_hold, idle_cycles;
   int failures, cmds_checked, reqs_accepted, settings_done, abs_clamps, slew_clamps;

   always #5 clock = ~clock;

   jacobian_torque_limiter dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_if),
      .rsp_chan  (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   function automatic logic signed [DATA_W-1:0] pick_q16();
      case ($urandom_range(0, 15))
         0:       return 32'sh7FFF_FFFF;
         1:       return 32'sh8000_0000;
         2:       return '0;
         3, 4:    return $urandom;
         default: return $signed($urandom_range(0, 2 ** 21)) - 2 ** 20;
      endcase
   endfunction

   function automatic logic [DT_W-1:0] pick_step();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return '1;
         2:       return DT_W'($urandom);
         default: return DT_W'($urandom_range(1, 2 ** 14));
      endcase
   endfunction

   function automatic logic [CFG_W-1:0] pick_cfg();
      case ($urandom_range(0, 5))
         0:       return '0;
         1:       return '1;
         2:       return CFG_W'($urandom);
         default: return CFG_W'($urandom_range(1, 2 ** 24));
      endcase
   endfunction

   function automatic req_type make_req(logic [KIND_W-1:0] k, int unsigned slot);
      req_type r;
      r.kind        = k;
      r.slot        = slot[SLOT_W-1:0];
      r.value       = pick_q16();
      r.jac_0       = pick_q16();
      r.jac_1       = pick_q16();
      r.jac_2       = pick_q16();
      r.jac_3       = pick_q16();
      r.jac_4       = pick_q16();
      r.jac_5       = pick_q16();
      r.step_time   = pick_step();
      r.handle_ok   = 1'($urandom_range(0, 1));
      r.final_joint = 1'($urandom_range(0, 1));
      return r;
   endfunction

   function automatic void compute_joint_command(req_type r);
      logic signed [DATA_W-1:0] jac [AXES];
      logic signed [WIDE_W-1:0] acc, tau, bound, prev, span;
      rsp_type cmd;
      int a;
      jac = '{r.jac_0, r.jac_1, r.jac_2, r.jac_3, r.jac_4, r.jac_5};
      case (r.kind)
         KIND_WRENCH: if (r.slot < AXES) wrench_axis[r.slot] = r.value;
         KIND_CLEAR:  history_valid = 1'b0;
         KIND_JOINT: begin
            cmd           = '0;
            cmd.joint_id  = r.slot;
            cmd.frame_end = r.final_joint;
            if (r.handle_ok && r.slot < MAX_JOINTS) begin
               acc = '0;
               for (a = 0; a < AXES; a++)
                  acc += WIDE_W'(jac[a]) * WIDE_W'(wrench_axis[a]);
               tau   = WIDE_W'(r.value) + (acc >>> FRAC_W);
               bound = WIDE_W'(limit_reg);
               if (tau > bound) begin
                  tau = bound;
                  abs_clamps++;
               end else if (tau < -bound) begin
                  tau = -bound;
                  abs_clamps++;
               end
               if (history_valid && r.step_time != 0) begin
                  span = (WIDE_W'(rate_reg) * WIDE_W'(r.step_time)) >> DT_W;
                  prev = WIDE_W'(prev_torque[r.slot]);
                  if (tau > prev + span) begin
                     tau = prev + span;
                     slew_clamps++;
                  end else if (tau < prev - span) begin
                     tau = prev - span;
                     slew_clamps++;
                  end
               end
               prev_torque[r.slot] = tau[DATA_W-1:0];
               if (r.final_joint) history_valid = 1'b1;
               cmd.torque_out    = tau[DATA_W-1:0];
               cmd.stiffness_out = kp_reg;
               cmd.damping_out   = kd_reg;
               cmd.command_ok    = 1'b1;
            end
            expected_cmds.push_back(cmd);
         end
         default: ;
      endcase
   endfunction

   task automatic program_regs(input logic [CFG_W-1:0] lim, rate, kp, kd);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= CSR_TORQUE_LIMIT;
      csr_wdata <= lim;
      @(posedge clock);
      csr_index <= CSR_RATE_LIMIT;
      csr_wdata <= rate;
      @(posedge clock);
      csr_index <= CSR_STIFFNESS;
      csr_wdata <= kp;
      @(posedge clock);
      csr_index <= CSR_DAMPING;
      csr_wdata <= kd;
      @(posedge clock);
      csr_we    <= 1'b0;
      limit_reg = lim;
      rate_reg  = rate;
      kp_reg    = kp;
      kd_reg    = kd;
      settings_done++;
   endtask

   task automatic wait_drained();
      while (pending_reqs.size() != 0 || req_if.valid || expected_cmds.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // request driver: predict on acceptance, then present the next pending transaction
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            compute_joint_command(req_if.data);
            reqs_accepted++;
         end
         if (!req_if.valid || req_if.ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_if.valid <= 1'b0;
            end else if (pending_reqs.size() != 0) begin
               req_if.data  <= pending_reqs.pop_front();
               req_if.valid <= 1'b1;
               if (!quiet_idle && $urandom_range(0, 9) == 0) send_gap = $urandom_range(1, 4);
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // command monitor: check against the oldest prediction, stall ready in bursts
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
         recv_hold = 0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_cmds.size() == 0) begin
               failures++;
               if (failures <= 10)
                  $display("unexpected command: joint %0d torque %h ok %b",
                           rsp_if.data.joint_id, rsp_if.data.torque_out,
                           rsp_if.data.command_ok);
            end else begin
               want = expected_cmds.pop_front();
               cmds_checked++;
               if (rsp_if.data !== want) begin
                  failures++;
                  if (failures <= 10) begin
                     $display("command %0d want: joint %0d torque %h kp %h kd %h ok %b end %b",
                              cmds_checked, want.joint_id, want.torque_out,
                              want.stiffness_out, want.damping_out, want.command_ok,
                              want.frame_end);
                     $display("command %0d got:  joint %0d torque %h kp %h kd %h ok %b end %b",
                              cmds_checked, rsp_if.data.joint_id, rsp_if.data.torque_out,
                              rsp_if.data.stiffness_out, rsp_if.data.damping_out,
                              rsp_if.data.command_ok, rsp_if.data.frame_end);
                  end
               end
            end
         end
         if (recv_hold > 0) begin
            recv_hold--;
            rsp_if.ready <= 1'b0;
         end else if (!quiet_idle && $urandom_range(0, 7) == 0) begin
            recv_hold = $urandom_range(0, 3);
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("no transaction for %0d cycles, %0d commands outstanding",
                     idle_cycles, expected_cmds.size());
            $display("FAILURE");
            $finish;
         end
      end
   end

   initial begin
      req_type                  r;
      logic signed [DATA_W-1:0] corner_vals [AXES];
      logic [DT_W-1:0]          frame_dt;
      int                       axis_order [AXES];
      int                       a, j, k, tmp, ph, made, n_axes, n_joints;
      bit                       frame_ok, broken, scattered;
      req_if.valid = 1'b0;
      req_if.data  = '0;
      rsp_if.ready = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      program_regs(CFG_MAX, CFG_MAX, CFG_MAX, 31'h2AAA_AAAA);
      @(negedge clock);

      corner_vals = '{32'sh7FFF_FFFF, 32'sh8000_0000, -32'sd1, 32'sd1,
                      32'sh0001_0000, 32'sh0000_8000};
      for (a = 0; a < AXES; a++) begin
         r = make_req(KIND_WRENCH, a);
         r.value = corner_vals[a];
         pending_reqs.push_back(r);
      end
      pending_reqs.push_back(make_req(KIND_WRENCH, 6));
      pending_reqs.push_back(make_req(KIND_WRENCH, 7));
      pending_reqs.push_back(make_req(KIND_UNUSED, $urandom_range(0, 7)));
      // first frame writes every joint's history before any slew check
      for (j = 0; j < MAX_JOINTS; j++) begin
         r = make_req(KIND_JOINT, j);
         r.handle_ok   = 1'b1;
         r.final_joint = (j == MAX_JOINTS - 1);
         if (j == 0) begin
            r.value = 32'sh8000_0000;
            {r.jac_0, r.jac_1, r.jac_2, r.jac_3, r.jac_4, r.jac_5} = {6{32'h8000_0000}};
            r.step_time = '1;
         end else if (j == 1) begin
            r.value = 32'sh7FFF_FFFF;
            {r.jac_0, r.jac_1, r.jac_2, r.jac_3, r.jac_4, r.jac_5} = {6{32'h7FFF_FFFF}};
         end else if (j == 2) begin
            r.value = 32'sd1;
            {r.jac_0, r.jac_1, r.jac_2, r.jac_3, r.jac_4, r.jac_5} = '0;
         end
         pending_reqs.push_back(r);
      end
      r = make_req(KIND_JOINT, 0);
      r.handle_ok   = 1'b0;
      r.final_joint = 1'b1;
      pending_reqs.push_back(r);
      for (j = 0; j < 3; j++) begin
         r = make_req(KIND_JOINT, j);
         r.handle_ok   = 1'b1;
         r.final_joint = (j == 2);
         r.step_time   = (j == 0) ? '1 : (j == 1) ? '0 : 24'd1;
         pending_reqs.push_back(r);
      end
      pending_reqs.push_back(make_req(KIND_CLEAR, 0));
      r = make_req(KIND_JOINT, 1);
      r.handle_ok   = 1'b1;
      r.final_joint = 1'b1;
      r.step_time   = '1;
      pending_reqs.push_back(r);

      for (ph = 1; ph <= PHASES; ph++) begin
         wait_drained();
         case (ph)
            1:       program_regs('0, CFG_MAX, '0, CFG_MAX);
            2:       program_regs(CFG_MAX, '0, CFG_MAX, '0);
            default: program_regs(pick_cfg(), pick_cfg(), pick_cfg(), pick_cfg());
         endcase
         @(negedge clock);
         quiet_idle = (ph == 5 || ph == PHASES);
         made = 0;
         while (made < PHASE_ITEMS) begin
            case ($urandom_range(0, 15))
               0: pending_reqs.push_back(make_req(KIND_UNUSED, $urandom_range(0, 7)));
               1: pending_reqs.push_back(make_req(KIND_WRENCH, $urandom_range(AXES, 7)));
               2: begin
                  pending_reqs.push_back(make_req(KIND_CLEAR, $urandom_range(0, 7)));
                  made++;
               end
               default: ;
            endcase
            for (a = 0; a < AXES; a++) axis_order[a] = a;
            for (a = AXES - 1; a > 0; a--) begin
               k = $urandom_range(0, a);
               tmp = axis_order[a];
               axis_order[a] = axis_order[k];
               axis_order[k] = tmp;
            end
            n_axes = ($urandom_range(0, 7) == 0) ? $urandom_range(0, AXES) : AXES;
            for (a = 0; a < n_axes; a++) begin
               pending_reqs.push_back(make_req(KIND_WRENCH, axis_order[a]));
               made++;
            end
            n_joints  = $urandom_range(1, MAX_JOINTS);
            frame_ok  = ($urandom_range(0, 7) != 0);
            broken    = ($urandom_range(0, 11) == 0);
            scattered = ($urandom_range(0, 5) == 0);
            frame_dt  = pick_step();
            for (j = 0; j < n_joints; j++) begin
               r = make_req(KIND_JOINT, scattered ? $urandom_range(0, MAX_JOINTS - 1) : j);
               r.handle_ok   = frame_ok ^ ($urandom_range(0, 19) == 0);
               r.final_joint = (j == n_joints - 1) && !broken;
               if ($urandom_range(0, 9) != 0) r.step_time = frame_dt;
               pending_reqs.push_back(r);
               made++;
            end
         end
      end

      wait_drained();
      $display("%0d requests over %0d register settings, %0d joint commands checked",
               reqs_accepted, settings_done, cmds_checked);
      $display("limits engaged: %0d absolute clamps, %0d slew clamps", abs_clamps, slew_clamps);
      if (failures == 0) begin
         $display("SUCCESS");
      end else begin
         $display("%0d mismatches", failures);
         $display("FAILURE");
      end
      $finish;
   end

endmodule
